[hw/rtl/arqrw_pkg.sv]
// Shared widths, mode codes and controller interface types for the ARQ receiver window.
package arqrw_pkg;

   localparam int SEQ_W         = 10;
   localparam int NUM_W         = 11;
   localparam int CNT_W         = 16;
   localparam int MODE_W        = 2;
   localparam int SEQ_LIMIT     = 2 ** SEQ_W;
   localparam int SEQ_SPACE_DEF = 1024;

   localparam logic [CNT_W-1:0]  CNT_MAX = '1;

   localparam logic [MODE_W-1:0] MODE_STOP_WAIT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_GO_BACK_N = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SELECTIVE = 2'd2;

   typedef struct packed {
      logic clear_wr;
      logic accept;
      logic scan_rd;
      logic scan_step;
      logic load_out;
   } arqrw_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic need_scan;
      logic at_limit;
      logic map_bit;
   } arqrw_stat_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] value);
      return (value == CNT_MAX) ? value : value + 1'b1;
   endfunction

endpackage

[hw/rtl/arqrw_req_if.sv]
// Input channel carrying one arrived frame per item.
interface arqrw_req_if import arqrw_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             frame_ok;
   logic [SEQ_W-1:0] seq_num;

   modport source (output valid, output frame_ok, output seq_num, input ready);
   modport sink   (input valid, input frame_ok, input seq_num, output ready);
endinterface

[hw/rtl/arqrw_rsp_if.sv]
// Result channel carrying the acknowledgement decision and counters per item.
interface arqrw_rsp_if import arqrw_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    ack_valid;
   logic signed [NUM_W-1:0] ack_seq;
   logic                    misordered;
   logic [NUM_W-1:0]        delivered_count;
   logic [NUM_W-1:0]        next_expected;
   logic [CNT_W-1:0]        received_total;
   logic [CNT_W-1:0]        corrupt_total;
   logic [CNT_W-1:0]        misordered_total;

   modport source (output valid, output ack_valid, output ack_seq, output misordered,
                   output delivered_count, output next_expected, output received_total,
                   output corrupt_total, output misordered_total, input ready);
   modport sink   (input valid, input ack_valid, input ack_seq, input misordered,
                   input delivered_count, input next_expected, input received_total,
                   input corrupt_total, input misordered_total, output ready);
endinterface

[hw/rtl/arqrw_ctrl.sv]
// Controller state machine: map clearing, item acceptance, window scan and result hand-off.
module arqrw_ctrl import arqrw_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  arqrw_stat_type stat,
   output arqrw_cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (stat.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = stat.need_scan ? ST_SCAN_RD : ST_OUT;
            end
         end
         ST_SCAN_RD: begin
            if (stat.at_limit) begin
               state_in = ST_OUT;
            end else begin
               cmd.scan_rd = 1'b1;
               state_in    = ST_SCAN_CHK;
            end
         end
         ST_SCAN_CHK: begin
            if (stat.map_bit) begin
               cmd.scan_step = 1'b1;
               state_in      = ST_SCAN_RD;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

[hw/rtl/arqrw_dpath.sv]
// Datapath: mode register, expected number, received bitmap memory, counters and result register.
module arqrw_dpath import arqrw_pkg::*; #(
   parameter int SEQ_SPACE = SEQ_SPACE_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  logic [MODE_W-1:0]       csr_wr_data,
   input  logic                    req_frame_ok,
   input  logic [SEQ_W-1:0]        req_seq_num,
   input  arqrw_cmd_type           cmd,
   output arqrw_stat_type          stat,
   output logic                    rsp_ack_valid,
   output logic signed [NUM_W-1:0] rsp_ack_seq,
   output logic                    rsp_misordered,
   output logic [NUM_W-1:0]        rsp_delivered_count,
   output logic [NUM_W-1:0]        rsp_next_expected,
   output logic [CNT_W-1:0]        rsp_received_total,
   output logic [CNT_W-1:0]        rsp_corrupt_total,
   output logic [CNT_W-1:0]        rsp_misordered_total
);

   // Only numbers below the seq_num field's range can ever be marked.
   localparam int MAP_DEPTH = (SEQ_SPACE < SEQ_LIMIT) ? SEQ_SPACE : SEQ_LIMIT;
   localparam int IDX_W     = $clog2(MAP_DEPTH);
   localparam int EXP_W     = $clog2(MAP_DEPTH + 1);

   logic                map_mem [MAP_DEPTH];
   logic                map_bit_ff;
   logic [IDX_W-1:0]    clr_idx_ff;
   logic [MODE_W-1:0]   mode_ff;
   logic [EXP_W-1:0]    exp_ff, exp_in;
   logic [NUM_W-1:0]    moved_ff, moved_in;
   logic [CNT_W-1:0]    good_ff, bad_ff, mis_ff;
   logic                ack_v_ff, ack_v_in;
   logic [NUM_W-1:0]    ack_s_ff, ack_s_in;
   logic                ooo_ff, ooo_in;
   logic                mark_in, step_one;

   logic                out_ack_v_ff, out_ooo_ff;
   logic [NUM_W-1:0]    out_ack_s_ff, out_moved_ff, out_exp_ff;
   logic [CNT_W-1:0]    out_good_ff, out_bad_ff, out_mis_ff;

   logic [NUM_W-1:0]    seq_ext, exp_ext, exp_prev;
   logic                in_space, seq_match, seq_above;

   assign seq_ext   = {1'b0, req_seq_num};
   assign exp_ext   = NUM_W'(exp_ff);
   assign exp_prev  = exp_ext - 1'b1;
   assign in_space  = seq_ext < NUM_W'(MAP_DEPTH);
   assign seq_match = seq_ext == exp_ext;
   assign seq_above = seq_ext > exp_ext;

   always_comb begin
      ack_v_in = 1'b0;
      ack_s_in = '0;
      ooo_in   = 1'b0;
      mark_in  = 1'b0;
      step_one = 1'b0;
      if (req_frame_ok) begin
         if (!in_space) begin
            ooo_in   = 1'b1;
            ack_v_in = 1'b1;
            ack_s_in = exp_prev;
         end else begin
            case (mode_ff)
               MODE_STOP_WAIT: begin
                  ack_v_in = 1'b1;
                  if (seq_match) begin
                     ack_s_in = seq_ext;
                     step_one = 1'b1;
                  end else begin
                     ooo_in   = 1'b1;
                     ack_s_in = exp_prev;
                  end
               end
               MODE_GO_BACK_N: begin
                  if (seq_match) begin
                     ack_v_in = 1'b1;
                     ack_s_in = seq_ext;
                     mark_in  = 1'b1;
                  end else begin
                     ooo_in   = 1'b1;
                     ack_v_in = seq_above;
                     ack_s_in = seq_above ? exp_prev : '0;
                  end
               end
               default: begin
                  // Selective repeat; the unused fourth code behaves the same.
                  ack_v_in = 1'b1;
                  ack_s_in = seq_ext;
                  if (seq_match || seq_above) begin
                     mark_in = 1'b1;
                  end else begin
                     ooo_in = 1'b1;
                  end
               end
            endcase
         end
      end
   end

   always_comb begin
      exp_in   = exp_ff;
      moved_in = moved_ff;
      if (cmd.accept) begin
         exp_in   = step_one ? exp_ff + 1'b1 : exp_ff;
         moved_in = step_one ? NUM_W'(1) : '0;
      end else if (cmd.scan_step) begin
         exp_in   = exp_ff + 1'b1;
         moved_in = moved_ff + 1'b1;
      end
   end

   assign stat.clear_last = (clr_idx_ff == IDX_W'(MAP_DEPTH - 1));
   assign stat.need_scan  = mark_in;
   assign stat.at_limit   = (exp_ff == EXP_W'(MAP_DEPTH));
   assign stat.map_bit    = map_bit_ff;

   always_ff @(posedge clock) begin
      if (cmd.clear_wr) begin
         map_mem[clr_idx_ff] <= 1'b0;
      end else if (cmd.accept && mark_in) begin
         map_mem[req_seq_num[IDX_W-1:0]] <= 1'b1;
      end
      if (cmd.scan_rd) begin
         map_bit_ff <= map_mem[exp_ff[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_idx_ff <= '0;
         mode_ff    <= MODE_STOP_WAIT;
         exp_ff     <= '0;
         good_ff    <= '0;
         bad_ff     <= '0;
         mis_ff     <= '0;
      end else begin
         if (cmd.clear_wr) begin
            clr_idx_ff <= clr_idx_ff + 1'b1;
         end
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
         exp_ff <= exp_in;
         if (cmd.accept) begin
            if (req_frame_ok) begin
               good_ff <= sat_inc(good_ff);
            end else begin
               bad_ff <= sat_inc(bad_ff);
            end
            if (ooo_in) begin
               mis_ff <= sat_inc(mis_ff);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      moved_ff <= moved_in;
      if (cmd.accept) begin
         ack_v_ff <= ack_v_in;
         ack_s_ff <= ack_s_in;
         ooo_ff   <= ooo_in;
      end
      if (cmd.load_out) begin
         out_ack_v_ff <= ack_v_ff;
         out_ack_s_ff <= ack_s_ff;
         out_ooo_ff   <= ooo_ff;
         out_moved_ff <= moved_ff;
         out_exp_ff   <= exp_ext;
         out_good_ff  <= good_ff;
         out_bad_ff   <= bad_ff;
         out_mis_ff   <= mis_ff;
      end
   end

   assign rsp_ack_valid        = out_ack_v_ff;
   assign rsp_ack_seq          = $signed(out_ack_s_ff);
   assign rsp_misordered       = out_ooo_ff;
   assign rsp_delivered_count  = out_moved_ff;
   assign rsp_next_expected    = out_exp_ff;
   assign rsp_received_total   = out_good_ff;
   assign rsp_corrupt_total    = out_bad_ff;
   assign rsp_misordered_total = out_mis_ff;

endmodule

[hw/rtl/arq_receiver_window.sv]
// ARQ receiver window top level.
//
// Each item on req_ch is one arrived frame: frame_ok low marks a corrupt frame,
// otherwise seq_num carries its sequence number. Each item yields exactly one
// item on rsp_ch with the acknowledgement decision, the window advance, the
// next expected number and the three saturating frame counters.
// csr_wr_en with csr_wr_data writes the mode: stop-and-wait, go-back-N or
// selective repeat; write it only while the block is idle.
// Flow: an accepted item that marks the bitmap in go-back-N or selective repeat
// starts a scan that reads the bitmap memory at the expected number, checks the
// bit read, and on a set bit advances the window by one entry and reads again;
// it stops at a clear bit or at the end of the sequence space. The result is then
// loaded into the output register; every other item goes there without a scan.
// One item is in work at a time; the next one is accepted at the edge where the
// result can first be taken.
// After reset the bitmap memory is cleared, one entry per cycle, across all 1024
// entries (SEQ_SPACE when smaller); no item is accepted during that pass.
// If rsp_ch stalls, the finished result waits in the output register and the
// next item is still accepted; its result waits until the register is free.
module arq_receiver_window import arqrw_pkg::*; #(
   parameter int SEQ_SPACE = SEQ_SPACE_DEF
) (
   input  logic              clock,
   input  logic              reset,
   arqrw_req_if.sink         req_ch,
   arqrw_rsp_if.source       rsp_ch,
   input  logic              csr_wr_en,
   input  logic [MODE_W-1:0] csr_wr_data
);

   arqrw_cmd_type  cmd;
   arqrw_stat_type stat;

   arqrw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   arqrw_dpath #(
      .SEQ_SPACE (SEQ_SPACE)
   ) u_dpath (
      .clock                (clock),
      .reset                (reset),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data),
      .req_frame_ok         (req_ch.frame_ok),
      .req_seq_num          (req_ch.seq_num),
      .cmd                  (cmd),
      .stat                 (stat),
      .rsp_ack_valid        (rsp_ch.ack_valid),
      .rsp_ack_seq          (rsp_ch.ack_seq),
      .rsp_misordered       (rsp_ch.misordered),
      .rsp_delivered_count  (rsp_ch.delivered_count),
      .rsp_next_expected    (rsp_ch.next_expected),
      .rsp_received_total   (rsp_ch.received_total),
      .rsp_corrupt_total    (rsp_ch.corrupt_total),
      .rsp_misordered_total (rsp_ch.misordered_total)
   );

endmodule

[hw/rtl/arqrw_checker.sv]
// Port-level assertion checker for the ARQ receiver window and its bind statement.
module arqrw_checker import arqrw_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic                    rsp_ack_valid,
   input logic signed [NUM_W-1:0] rsp_ack_seq,
   input logic                    rsp_misordered,
   input logic [NUM_W-1:0]        rsp_delivered_count,
   input logic [CNT_W-1:0]        rsp_received_total
);

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_one_item_in_work: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second item accepted while one is in work");

   a_no_ack_zero_seq: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ack_valid) |-> (rsp_ack_seq == '0))
      else $error("ack_seq nonzero without an acknowledgement");

   a_ooo_no_advance: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_misordered) |-> (rsp_delivered_count == '0))
      else $error("window advanced on an out-of-order frame");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_received_total)))
      else $error("stalled result changed");

endmodule

bind arq_receiver_window arqrw_checker u_arqrw_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_ch.valid),
   .req_ready           (req_ch.ready),
   .rsp_valid           (rsp_ch.valid),
   .rsp_ready           (rsp_ch.ready),
   .rsp_ack_valid       (rsp_ch.ack_valid),
   .rsp_ack_seq         (rsp_ch.ack_seq),
   .rsp_misordered      (rsp_ch.misordered),
   .rsp_delivered_count (rsp_ch.delivered_count),
   .rsp_received_total  (rsp_ch.received_total)
);

[test/arq_receiver_window_test.sv]
// Self-checking testbench for the ARQ receiver window: directed, random and stress traffic.
`timescale 1ns / 1ps

module arq_receiver_window_test;
   import arqrw_pkg::*;

   localparam int SPACE        = SEQ_SPACE_DEF;
   localparam int IDLE_PCT     = 29;
   localparam int CORRUPT_PCT  = 15;

   localparam logic [MODE_W-1:0] MODE_RESERVED = 2'd3;
   localparam logic [MODE_W-1:0] ALL_MODES [4] =
      '{MODE_STOP_WAIT, MODE_GO_BACK_N, MODE_SELECTIVE, MODE_RESERVED};

   typedef struct {
      logic                    ack_valid;
      logic signed [NUM_W-1:0] ack_seq;
      logic                    misordered;
      logic [NUM_W-1:0]        delivered_count;
      logic [NUM_W-1:0]        next_expected;
      logic [CNT_W-1:0]        received_total;
      logic [CNT_W-1:0]        corrupt_total;
      logic [CNT_W-1:0]        misordered_total;
   } ack_report_type;

   logic              clock;
   logic              reset;
   logic              csr_wr_en;
   logic [MODE_W-1:0] csr_wr_data;

   arqrw_req_if req_ch ();
   arqrw_rsp_if rsp_ch ();

   arq_receiver_window i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   logic [MODE_W-1:0] mode_shadow       = MODE_STOP_WAIT;
   int unsigned       window_base       = 0;
   bit                accepted_map [SPACE];
   logic [CNT_W-1:0]  good_frames       = '0;
   logic [CNT_W-1:0]  corrupt_frames    = '0;
   logic [CNT_W-1:0]  misordered_frames = '0;

   ack_report_type pending_acks [$];
   int unsigned errors         = 0;
   int unsigned holdoff_cycles = 0;
   bit          idle_on        = 1'b1;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #40_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic logic [CNT_W-1:0] held_inc(input logic [CNT_W-1:0] v);
      return (v < CNT_MAX) ? v + 1'b1 : v;
   endfunction

   function automatic int unsigned slide_window();
      int unsigned moved;
      moved = 0;
      while (window_base < SPACE && accepted_map[window_base]) begin
         window_base++;
         moved++;
      end
      return moved;
   endfunction

   function automatic ack_report_type predict_ack(input bit ok,
                                                  input logic [SEQ_W-1:0] seq);
      ack_report_type   r;
      int unsigned      s;
      logic [NUM_W-1:0] last_in_order;
      r = '{default: '0};
      s = 32'(seq);
      last_in_order = NUM_W'(window_base - 1);
      if (!ok) begin
         corrupt_frames = held_inc(corrupt_frames);
      end else begin
         good_frames = held_inc(good_frames);
         case (mode_shadow)
            MODE_STOP_WAIT: begin
               r.ack_valid = 1'b1;
               if (s == window_base) begin
                  r.ack_seq = NUM_W'(s);
                  window_base++;
                  r.delivered_count = NUM_W'(1);
               end else begin
                  r.misordered = 1'b1;
                  r.ack_seq = last_in_order;
               end
            end
            MODE_GO_BACK_N: begin
               if (s == window_base) begin
                  r.ack_valid = 1'b1;
                  r.ack_seq = NUM_W'(s);
                  accepted_map[s] = 1'b1;
                  r.delivered_count = NUM_W'(slide_window());
               end else begin
                  r.misordered = 1'b1;
                  if (s > window_base) begin
                     r.ack_valid = 1'b1;
                     r.ack_seq = last_in_order;
                  end
               end
            end
            default: begin
               r.ack_valid = 1'b1;
               r.ack_seq = NUM_W'(s);
               if (s >= window_base) begin
                  accepted_map[s] = 1'b1;
                  r.delivered_count = NUM_W'(slide_window());
               end else begin
                  r.misordered = 1'b1;
               end
            end
         endcase
         if (r.misordered) misordered_frames = held_inc(misordered_frames);
      end
      r.next_expected    = NUM_W'(window_base);
      r.received_total   = good_frames;
      r.corrupt_total    = corrupt_frames;
      r.misordered_total = misordered_frames;
      return r;
   endfunction

   function automatic logic [SEQ_W-1:0] pick_seq();
      int unsigned roll;
      int unsigned base;
      int unsigned s;
      roll = $urandom_range(99);
      base = (window_base < SPACE) ? window_base : SPACE - 1;
      if (roll < 50) begin
         s = base + $urandom_range(3);
         if (s > SPACE - 1) s = SPACE - 1;
      end else if (roll < 70) begin
         s = $urandom_range(base);
      end else if (roll < 90) begin
         s = $urandom_range(SPACE - 1);
      end else begin
         s = $urandom_range(1) ? SPACE - 1 : 0;
      end
      return SEQ_W'(s);
   endfunction

   task automatic compare_field(input string field, input logic signed [31:0] want,
                                input logic signed [31:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
      end
   endtask

   task automatic check_result();
      ack_report_type want;
      if (pending_acks.size() == 0) begin
         errors++;
         $display("%0t: result item with no expected item waiting", $time);
      end else begin
         want = pending_acks.pop_front();
         compare_field("ack_valid", 32'(want.ack_valid), 32'(rsp_ch.ack_valid));
         compare_field("ack_seq", 32'(want.ack_seq), 32'(rsp_ch.ack_seq));
         compare_field("misordered", 32'(want.misordered), 32'(rsp_ch.misordered));
         compare_field("delivered_count", 32'(want.delivered_count),
                       32'(rsp_ch.delivered_count));
         compare_field("next_expected", 32'(want.next_expected),
                       32'(rsp_ch.next_expected));
         compare_field("received_total", 32'(want.received_total),
                       32'(rsp_ch.received_total));
         compare_field("corrupt_total", 32'(want.corrupt_total),
                       32'(rsp_ch.corrupt_total));
         compare_field("misordered_total", 32'(want.misordered_total),
                       32'(rsp_ch.misordered_total));
      end
   endtask

   initial begin : result_sink
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) check_result();
         if (holdoff_cycles > 0) begin
            holdoff_cycles--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   task automatic send_frame(input bit ok, input logic [SEQ_W-1:0] seq);
      while (idle_on && $urandom_range(99) < IDLE_PCT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.frame_ok <= ok;
      req_ch.seq_num  <= seq;
      do @(posedge clock); while (!req_ch.ready);
      pending_acks.push_back(predict_ack(ok, seq));
   endtask

   task automatic send_random_frame();
      bit ok;
      ok = ($urandom_range(99) >= CORRUPT_PCT);
      send_frame(ok, pick_seq());
   endtask

   task automatic wait_drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending_acks.size() != 0);
   endtask

   task automatic write_mode(input logic [MODE_W-1:0] m);
      wait_drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= m;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      mode_shadow = m;
   endtask

   task automatic test_directed();
      send_frame(1'b1, 3);
      send_frame(1'b0, SPACE - 1);
      send_frame(1'b1, 0);
      send_frame(1'b1, 1);
      send_frame(1'b1, 1);
      send_frame(1'b0, 0);
      write_mode(MODE_GO_BACK_N);
      send_frame(1'b1, 4);
      send_frame(1'b1, 0);
      send_frame(1'b1, 2);
      send_frame(1'b1, 3);
      write_mode(MODE_SELECTIVE);
      send_frame(1'b1, 6);
      send_frame(1'b1, 5);
      send_frame(1'b1, SPACE - 1);
      send_frame(1'b1, 1);
      send_frame(1'b1, 4);
      write_mode(MODE_RESERVED);
      send_frame(1'b1, 8);
      send_frame(1'b1, 11);
      send_frame(1'b1, 7);
      write_mode(MODE_GO_BACK_N);
      send_frame(1'b1, 10);
      send_frame(1'b1, 9);
      send_frame(1'b1, 10);
      write_mode(MODE_STOP_WAIT);
      send_frame(1'b1, 12);
   endtask

   task automatic test_random_traffic();
      int unsigned n;
      repeat (8) begin
         write_mode(ALL_MODES[$urandom_range(3)]);
         n = $urandom_range(30, 70);
         repeat (n) send_random_frame();
      end
      idle_on = 1'b0;
      repeat (40) send_random_frame();
      idle_on = 1'b1;
   endtask

   task automatic test_backpressure();
      write_mode(MODE_SELECTIVE);
      idle_on = 1'b0;
      holdoff_cycles = 200;
      repeat (24) send_random_frame();
      wait_drain();
      repeat (16) send_random_frame();
      idle_on = 1'b1;
   endtask

   task automatic test_window_fill();
      int s;
      write_mode(MODE_SELECTIVE);
      if (window_base < SPACE) begin
         for (s = SPACE - 1; s > int'(window_base); s--) send_frame(1'b1, SEQ_W'(s));
         send_frame(1'b1, SEQ_W'(window_base));
      end
      foreach (ALL_MODES[i]) begin
         write_mode(ALL_MODES[i]);
         repeat (6) send_random_frame();
      end
   endtask

   task automatic test_no_idle_mix();
      write_mode(MODE_SELECTIVE);
      idle_on = 1'b0;
      repeat (16) send_random_frame();
      idle_on = 1'b1;
      write_mode(MODE_GO_BACK_N);
      repeat (4) send_random_frame();
      write_mode(MODE_STOP_WAIT);
      repeat (4) send_random_frame();
   endtask

   initial begin : stimulus
      reset           = 1'b1;
      csr_wr_en       = 1'b0;
      csr_wr_data     = MODE_STOP_WAIT;
      req_ch.valid    = 1'b0;
      req_ch.frame_ok = 1'b0;
      req_ch.seq_num  = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_traffic();
      test_backpressure();
      test_window_fill();
      test_no_idle_mix();
      wait_drain();
      repeat (64) @(posedge clock);
      if (errors == 0 && pending_acks.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
